/* rtl/jsu_pkg.sv */
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_DONE       = 4'd1;
  localparam logic [3:0] ST_NOQUOTE    = 4'd2;
  localparam logic [3:0] ST_UNTERM_ESC = 4'd3;
  localparam logic [3:0] ST_TRUNC_U    = 4'd4;
  localparam logic [3:0] ST_MISS_LOW   = 4'd5;
  localparam logic [3:0] ST_BAD_LOW    = 4'd6;
  localparam logic [3:0] ST_BAD_HEX    = 4'd7;
  localparam logic [3:0] ST_BAD_ESC    = 4'd8;
  localparam logic [3:0] ST_UNTERM     = 4'd9;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef enum logic [6:0] {
    PH_WAIT   = 7'b0000001,
    PH_STRING = 7'b0000010,
    PH_ESCAPE = 7'b0000100,
    PH_HEX1   = 7'b0001000,
    PH_BSLASH = 7'b0010000,
    PH_U      = 7'b0100000,
    PH_HEX2   = 7'b1000000
  } phase_t;

  // nbytes 0 marks a status-only word
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic [3:0]  status;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h7F) begin
      n = 3'd1;
    end else if (cp <= 21'h7FF) begin
      n = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (n)
      3'd2: begin
        b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      3'd3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        unique case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

/* rtl/jsu_front.sv */
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       mode,
  input  logic [7:0] char_byte,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output entry_t     push_data
);

  phase_t      phase, phase_next;
  logic [15:0] acc, acc_next;
  logic [9:0]  hs, hs_next;
  logic [1:0]  cnt, cnt_next;

  hex_t        hx;
  logic [15:0] acc_sh;
  entry_t      ent;

  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign push_data = ent;

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    hs_next    = hs;
    cnt_next   = cnt;
    ent        = '0;
    hx         = hex_decode(char_byte);
    acc_sh     = {acc[11:0], hx.val};
    if (mode) begin
      unique case (phase)
        PH_STRING: ent.status = ST_UNTERM;
        PH_ESCAPE: ent.status = ST_UNTERM_ESC;
        PH_HEX1:   ent.status = ST_TRUNC_U;
        PH_BSLASH, PH_U, PH_HEX2: ent.status = ST_MISS_LOW;
        default:   ent.status = ST_NOQUOTE;
      endcase
    end else begin
      unique case (phase)
        PH_STRING: begin
          if (char_byte == CH_QUOTE) begin
            ent.status = ST_DONE;
          end else if (char_byte == CH_BSLASH) begin
            phase_next = PH_ESCAPE;
          end else begin
            ent.cp     = {13'd0, char_byte};
            ent.nbytes = 3'd1;
          end
        end
        PH_ESCAPE: begin
          phase_next = PH_STRING;
          ent.nbytes = 3'd1;
          unique case (char_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: ent.cp = {13'd0, char_byte};
            CH_B: ent.cp = 21'h08;
            CH_F: ent.cp = 21'h0C;
            CH_N: ent.cp = 21'h0A;
            CH_R: ent.cp = 21'h0D;
            CH_T: ent.cp = 21'h09;
            CH_U: begin
              phase_next = PH_HEX1;
              acc_next   = '0;
              cnt_next   = '0;
              ent.nbytes = 3'd0;
            end
            default: begin
              ent.nbytes = 3'd0;
              ent.status = ST_BAD_ESC;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!hx.ok) begin
            ent.status = ST_BAD_HEX;
          end else if (cnt != 2'd3) begin
            acc_next = acc_sh;
            cnt_next = cnt + 2'd1;
          end else begin
            cnt_next = '0;
            acc_next = '0;
            if (phase == PH_HEX1) begin
              if (acc_sh >= HI_SUR_MIN && acc_sh <= HI_SUR_MAX) begin
                hs_next    = acc_sh[9:0];
                phase_next = PH_BSLASH;
              end else begin
                ent.cp     = {5'd0, acc_sh};
                ent.nbytes = cp_len({5'd0, acc_sh});
                phase_next = PH_STRING;
              end
            end else begin
              if (acc_sh < LO_SUR_MIN || acc_sh > LO_SUR_MAX) begin
                ent.status = ST_BAD_LOW;
              end else begin
                ent.cp     = SUPP_BASE + {1'b0, hs, acc_sh[9:0]};
                ent.nbytes = 3'd4;
                phase_next = PH_STRING;
              end
            end
          end
        end
        PH_BSLASH: begin
          if (char_byte == CH_BSLASH) begin
            phase_next = PH_U;
          end else begin
            ent.status = ST_MISS_LOW;
          end
        end
        PH_U: begin
          if (char_byte == CH_U) begin
            phase_next = PH_HEX2;
            acc_next   = '0;
            cnt_next   = '0;
          end else begin
            ent.status = ST_MISS_LOW;
          end
        end
        default: begin
          if (char_byte == CH_QUOTE) begin
            phase_next = PH_STRING;
          end else begin
            ent.status = ST_NOQUOTE;
          end
        end
      endcase
    end
    if (ent.status != ST_OK) begin
      phase_next = PH_WAIT;
      acc_next   = '0;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      acc   <= '0;
      hs    <= '0;
      cnt   <= '0;
    end else if (push) begin
      phase <= phase_next;
      acc   <= acc_next;
      hs    <= hs_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* rtl/jsu_queue.sv */
module jsu_queue import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t         store [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/jsu_back.sv */
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data,
  output logic        out_last
);

  logic [1:0] idx;
  logic       load;
  logic       fin;
  logic [7:0] ob;

  assign load = !out_valid || out_ready;
  assign fin  = (head.nbytes == 3'd0) || ({1'b0, idx} == head.nbytes - 3'd1);
  assign pop  = load && !empty && fin;
  assign ob   = utf8_byte(head.cp, head.nbytes, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= fin ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (head.nbytes == 3'd0) begin
        out_data <= {3'd0, head.status, 1'b0, 8'h00};
      end else begin
        out_data <= {3'd0, ST_OK, 1'b1, ob};
      end
      out_last <= fin;
    end
  end

endmodule

/* rtl/json_string_unescape.sv */
// path: each input word is written into a queue entry, then the back end registers its first result word
// throughput: one input word per cycle; a code point emits 1 to 4 result words,
// one per cycle from the back end while the output is ready, with a four-entry queue between the two halves
// input stalls only when that queue is full
// reset: synchronous, active high; waits for an opening quote, queue empty, no output
module json_string_unescape import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_byte
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte, byte_valid, status, zero pad
  output logic        m_axis_tlast   // last
);

  logic   push;
  entry_t push_data;
  logic   pop;
  entry_t head;
  logic   q_full;
  logic   q_empty;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .mode      (s_axis_tuser),
    .char_byte (s_axis_tdata),
    .q_full    (q_full),
    .in_ready  (s_axis_tready),
    .push      (push),
    .push_data (push_data)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

/* rtl/jsu_checker.sv */
module jsu_checker import jsu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // decoded bytes only carry status ok
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[12:9] == ST_OK)
    else $error("decoded byte with non-zero status");

  // a status-only word is always the last of its input word
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
    else $error("status word not last or carries a byte");

  // status code in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[12:9] <= ST_UNTERM && m_axis_tdata[15:13] == 3'd0)
    else $error("status code out of range");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind json_string_unescape jsu_checker u_chk (.*);

/* dv/json_string_unescape_chk.sv */
`timescale 1ns / 1ps
module json_string_unescape_chk import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_byte
  input  logic        s_axis_tuser,  // mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // out_byte, byte_valid, status, zero pad
  input  logic        m_axis_tlast,  // last
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic [3:0] st;
    logic       lst;
  } result_t;

  result_t     unescaped_q[$];
  phase_t      ph;
  logic [15:0] acc;
  logic [9:0]  hi_bits;
  logic [1:0]  ndig;

  // bit 4 set when the byte is a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      return {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      return {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return 5'd0;
  endfunction

  task automatic put_word(input logic [7:0] ch, input logic vld, input logic [3:0] st,
                          input logic lst);
    result_t r;
    r.ch  = ch;
    r.vld = vld;
    r.st  = st;
    r.lst = lst;
    unescaped_q.insert(unescaped_q.size(), r);
  endtask

  task automatic end_with(input logic [3:0] st);
    put_word(8'h00, 1'b0, st, 1'b1);
    if (st != ST_OK) begin
      ph   = PH_WAIT;
      acc  = '0;
      ndig = '0;
    end
  endtask

  task automatic put_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_word(cp[7:0], 1'b1, ST_OK, 1'b1);
    end else if (cp <= 21'h7FF) begin
      put_word(8'hC0 | 8'(cp[10:6]), 1'b1, ST_OK, 1'b0);
      put_word(8'h80 | 8'(cp[5:0]), 1'b1, ST_OK, 1'b1);
    end else if (cp <= 21'hFFFF) begin
      put_word(8'hE0 | 8'(cp[15:12]), 1'b1, ST_OK, 1'b0);
      put_word(8'h80 | 8'(cp[11:6]), 1'b1, ST_OK, 1'b0);
      put_word(8'h80 | 8'(cp[5:0]), 1'b1, ST_OK, 1'b1);
    end else begin
      put_word(8'hF0 | 8'(cp[20:18]), 1'b1, ST_OK, 1'b0);
      put_word(8'h80 | 8'(cp[17:12]), 1'b1, ST_OK, 1'b0);
      put_word(8'h80 | 8'(cp[11:6]), 1'b1, ST_OK, 1'b0);
      put_word(8'h80 | 8'(cp[5:0]), 1'b1, ST_OK, 1'b1);
    end
  endtask

  task automatic predict_unescape(input logic eot, input logic [7:0] c);
    logic [4:0]  d;
    logic [20:0] cp;
    logic [7:0]  esc;
    logic        known;
    if (eot) begin
      case (ph)
        PH_STRING:                 end_with(ST_UNTERM);
        PH_ESCAPE:                 end_with(ST_UNTERM_ESC);
        PH_HEX1:                   end_with(ST_TRUNC_U);
        PH_BSLASH, PH_U, PH_HEX2:  end_with(ST_MISS_LOW);
        default:                   end_with(ST_NOQUOTE);
      endcase
    end else begin
      case (ph)
        PH_STRING: begin
          if (c == CH_QUOTE) begin
            end_with(ST_DONE);
          end else if (c == CH_BSLASH) begin
            ph = PH_ESCAPE;
            end_with(ST_OK);
          end else begin
            put_word(c, 1'b1, ST_OK, 1'b1);
          end
        end
        PH_ESCAPE: begin
          known = 1'b1;
          esc   = c;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
            CH_B:    esc = 8'h08;
            CH_F:    esc = 8'h0C;
            CH_N:    esc = 8'h0A;
            CH_R:    esc = 8'h0D;
            CH_T:    esc = 8'h09;
            default: known = 1'b0;
          endcase
          if (c == CH_U) begin
            ph   = PH_HEX1;
            acc  = '0;
            ndig = '0;
            end_with(ST_OK);
          end else if (!known) begin
            end_with(ST_BAD_ESC);
          end else begin
            ph = PH_STRING;
            put_word(esc, 1'b1, ST_OK, 1'b1);
          end
        end
        PH_HEX1, PH_HEX2: begin
          d = nibble_of(c);
          if (!d[4]) begin
            end_with(ST_BAD_HEX);
          end else begin
            acc = {acc[11:0], d[3:0]};
            if (ndig != 2'd3) begin
              ndig = ndig + 2'd1;
              end_with(ST_OK);
            end else begin
              ndig = '0;
              if (ph == PH_HEX1 && acc >= HI_SUR_MIN && acc <= HI_SUR_MAX) begin
                hi_bits = acc[9:0];
                acc     = '0;
                ph      = PH_BSLASH;
                end_with(ST_OK);
              end else if (ph == PH_HEX2 && (acc < LO_SUR_MIN || acc > LO_SUR_MAX)) begin
                end_with(ST_BAD_LOW);
              end else begin
                cp  = (ph == PH_HEX1) ? {5'd0, acc} : SUPP_BASE + {1'b0, hi_bits, acc[9:0]};
                acc = '0;
                ph  = PH_STRING;
                put_code_point(cp);
              end
            end
          end
        end
        PH_BSLASH: begin
          if (c != CH_BSLASH) begin
            end_with(ST_MISS_LOW);
          end else begin
            ph = PH_U;
            end_with(ST_OK);
          end
        end
        PH_U: begin
          if (c != CH_U) begin
            end_with(ST_MISS_LOW);
          end else begin
            ph   = PH_HEX2;
            acc  = '0;
            ndig = '0;
            end_with(ST_OK);
          end
        end
        default: begin
          if (c != CH_QUOTE) begin
            end_with(ST_NOQUOTE);
          end else begin
            ph = PH_STRING;
            end_with(ST_OK);
          end
        end
      endcase
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      ph      = PH_WAIT;
      acc     = '0;
      hi_bits = '0;
      ndig    = '0;
      unescaped_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (unescaped_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected word tdata=%h tlast=%b", $realtime, m_axis_tdata,
                     m_axis_tlast);
          end
        end else begin
          want = unescaped_q.pop_front();
          if (m_axis_tdata[7:0] !== want.ch || m_axis_tdata[8] !== want.vld ||
              m_axis_tdata[12:9] !== want.st || m_axis_tdata[15:13] !== 3'd0 ||
              m_axis_tlast !== want.lst) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp byte=%h vld=%b st=%0d last=%b", $realtime,
                       want.ch, want.vld, want.st, want.lst);
              $display("%0t:          got byte=%h vld=%b st=%0d last=%b pad=%b", $realtime,
                       m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[12:9],
                       m_axis_tlast, m_axis_tdata[15:13]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_unescape(s_axis_tuser, s_axis_tdata);
      end
    end
    pending = unescaped_q.size();
  end

endmodule

/* dv/json_string_unescape_tb.sv */
`timescale 1ns / 1ps
module json_string_unescape_tb;
  import jsu_pkg::*;

  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } text_item_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  int          pending;
  int          errors;
  int          sent;
  bit          tx_idle;
  bit          rx_idle;
  text_item_t  text_q[$];

  json_string_unescape dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  json_string_unescape_chk chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pending       (pending),
    .errors        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("json_string_unescape_tb failed");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) begin
      return 8'h30 + 8'(v);
    end
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic bit hex_like(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  task automatic add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), {1'b0, c});
  endtask

  task automatic add_eot();
    text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i]);
    end
  endtask

  task automatic add_u(input logic [15:0] v);
    add_char(CH_BSLASH);
    add_char(CH_U);
    for (int i = 3; i >= 0; i--) begin
      add_char(hex_char(v[i*4 +: 4], bit'($urandom_range(0, 1))));
    end
  endtask

  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endcase
  endfunction

  task automatic send_item(input text_item_t it);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.eot;
    s_axis_tdata  <= it.ch;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic flush_text();
    while (text_q.size() > 0) begin
      send_item(text_q.pop_front());
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // one quoted string with random content, sometimes broken
  task automatic build_text();
    int          keep;
    int          pos;
    logic [7:0]  c;
    logic [15:0] hi;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) add_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 15) == 0) begin
      add_eot();
    end
    add_char(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE || c == CH_BSLASH) begin
            c = c ^ 8'h01;
          end
          add_char(c);
        end
        4, 5: begin
          add_char(CH_BSLASH);
          case ($urandom_range(0, 7))
            0:       add_char(CH_QUOTE);
            1:       add_char(CH_BSLASH);
            2:       add_char(CH_SLASH);
            3:       add_char(CH_B);
            4:       add_char(CH_F);
            5:       add_char(CH_N);
            6:       add_char(CH_R);
            default: add_char(CH_T);
          endcase
        end
        6, 7: add_u(pick_bmp());
        default: begin
          hi = 16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX));
          add_u(hi);
          case ($urandom_range(0, 7))
            0:       add_u(16'($urandom_range(0, 16'hFFFF)));
            1:       add_char(8'($urandom_range(0, 255)));
            2: begin
              add_char(CH_BSLASH);
              add_char(8'($urandom_range(0, 255)));
            end
            default: add_u(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
          endcase
        end
      endcase
    end
    case ($urandom_range(0, 13))
      0: begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) void'(text_q.pop_back());
        add_eot();
      end
      1: begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = {1'b0, 8'($urandom_range(0, 255))};
        add_char(CH_QUOTE);
      end
      2: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B || c == CH_F ||
            c == CH_N || c == CH_R || c == CH_T || c == CH_U) begin
          c = 8'h61;
        end
        add_char(CH_BSLASH);
        add_char(c);
      end
      3: add_eot();
      4: begin
        add_char(CH_BSLASH);
        add_char(CH_U);
        repeat ($urandom_range(0, 3)) add_char(hex_char(4'($urandom_range(0, 15)), 1'b1));
        c = 8'($urandom_range(0, 255));
        if (hex_like(c)) begin
          c = 8'h67;
        end
        add_char(c);
      end
      5: begin
        add_char(CH_BSLASH);
        add_char(CH_U);
        repeat ($urandom_range(0, 3)) add_char(hex_char(4'($urandom_range(0, 15)), 1'b0));
        add_eot();
      end
      default: add_char(CH_QUOTE);
    endcase
  endtask

  initial begin : stimulus
    int  target;
    bit  pressed;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    sent          = 0;
    pressed       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // end of text and a stray byte while waiting
    add_eot();
    add_char(8'hFF);
    // plain extremes, largest pair, largest bmp value, a short escape, close
    add_char(CH_QUOTE);
    add_char(8'h00);
    add_char(8'hFF);
    add_str("\\uDBFF\\uDFFF\\uffff\\t\"");
    // cut after backslash, inside digits, after high half
    add_str("\"\\");
    add_eot();
    add_str("\"\\u1");
    add_eot();
    add_str("\"\\uD800");
    add_eot();
    // high half not followed by an escape, or by a non-low value
    add_str("\"\\uD800x\"\\uD800\\uE000");
    // bad digit, unknown letter, unterminated string
    add_str("\"\\ug\"\\q\"");
    add_eot();
    flush_text();
    drain();

    target = sent + 360;
    while (sent < target) begin
      if (target - sent < 60) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      build_text();
      flush_text();
      if (!pressed && sent > target - 180) begin
        drain();
        pressed = 1'b1;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("json_string_unescape_tb passed");
    end else begin
      $display("json_string_unescape_tb failed");
    end
    $finish;
  end

endmodule
